// File: sv/lsw_pkg.sv
// Shared types and constants for the LCD shadow write filter.
package lsw_pkg;

    // Depth of the shadow store, a power of two between 16 and 256.
    localparam int STORE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int BYTE_W      = 8;

    localparam logic [BYTE_W-1:0] CURSOR_CMD_BIT = 8'h80;
    localparam logic [BYTE_W-1:0] ADDR_MASK      = 8'h7F;

    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_CMD  = 1'b1;

    localparam logic RS_CMD  = 1'b0;
    localparam logic RS_DATA = 1'b1;

    typedef logic [ADDR_W-1:0] addr_t;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    // One panel write as it leaves the block.
    typedef struct packed {
        logic              reg_select;
        logic [BYTE_W-1:0] bus_byte;
        logic              last;
    } result_t;

    // Load request from the control logic to the output queue.
    typedef struct packed {
        logic       load;
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } queue_load_t;

endpackage

// File: sv/lsw_shadow_mem.sv
// Shadow copy of display memory with per-entry valid bits and a registered read port.
module lsw_shadow_mem (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       rd_en,
    input  lsw_pkg::addr_t             rd_addr,
    output logic [lsw_pkg::BYTE_W-1:0] rd_data,
    input  logic                       wr_en,
    input  lsw_pkg::addr_t             wr_addr,
    input  logic [lsw_pkg::BYTE_W-1:0] wr_data
);
    import lsw_pkg::*;

    logic [BYTE_W-1:0]      mem [STORE_DEPTH];
    logic [STORE_DEPTH-1:0] valid_reg;
    logic [BYTE_W-1:0]      rd_data_reg;
    logic                   rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // An entry that was never written reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// File: sv/lsw_out_queue.sv
// Two-entry output queue that holds the panel writes of one input transaction.
module lsw_out_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lsw_pkg::queue_load_t req,
    input  logic                 pop,
    output logic                 empty,
    output lsw_pkg::result_t     head
);
    import lsw_pkg::*;

    logic [1:0] count_reg, count_next;
    result_t    slot0_reg, slot0_next;
    result_t    slot1_reg, slot1_next;

    // A load is only requested while the queue is empty, so it never meets a pop.
    always_comb
    begin
        count_next = count_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (req.load)
        begin
            count_next = req.count;
            slot0_next = req.first;
            slot1_next = req.second;
        end
        else if (pop)
        begin
            count_next = count_reg - 2'd1;
            slot0_next = slot1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    assign empty = (count_reg == 2'd0);
    assign head  = slot0_reg;

endmodule

// File: sv/lcd_shadow_write_filter_unit.sv
// Top level of the LCD shadow write filter: control, cursors, shadow store and output queue.
//
// Input channel (in_valid, in_stall, op, value): one transaction is a character (op 0)
// or a command byte (op 1). Output channel (out_valid, out_stall, reg_select, bus_byte,
// last): each transaction is one panel write; last marks the final write of an input.
// An input causes zero, one or two panel writes. A repeated character and a cursor
// command (bit 7 set) cause none and only move the logical cursor.
// The shadow store is read at the accepting edge (synchronous read port) and the
// following lookup cycle compares and writes back; the panel writes that it decides
// are registered in the output queue before they are offered. A new input is taken
// only in the idle state, never while the lookup of the last one is pending.
// The lookup cycle waits until the output queue has drained, so while the receiver
// stalls at most one more input is taken and then in_stall stays high.
// Reset clears both cursors, the output queue and the valid bits of the shadow store,
// so every entry reads as zero immediately after reset with no clearing pass.
module lcd_shadow_write_filter_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       op,
    input  logic [lsw_pkg::BYTE_W-1:0] value,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       reg_select,
    output logic [lsw_pkg::BYTE_W-1:0] bus_byte,
    output logic                       last
);
    import lsw_pkg::*;

    state_t            state_reg, state_next;
    addr_t             cursor_reg, cursor_next;
    addr_t             panel_reg, panel_next;
    logic              op_reg;
    logic [BYTE_W-1:0] value_reg;

    logic              accept;
    logic              go;
    logic              pop;
    logic              q_empty;
    result_t           q_head;
    queue_load_t       q_req;
    logic [BYTE_W-1:0] rd_data;
    logic              wr_en;
    addr_t             cursor_inc;
    logic [BYTE_W-1:0] cmd_addr;
    result_t           set_addr_res;
    result_t           data_res;
    result_t           cmd_res;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (q_empty)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb
    begin
        in_stall = 1'b1;
        go       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            ST_LOOKUP:
            begin
                go = q_empty;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    assign accept = in_valid && !in_stall;
    assign pop    = out_valid && !out_stall;

    assign cursor_inc = (cursor_reg == addr_t'(STORE_DEPTH - 1)) ? '0 : cursor_reg + 1'b1;
    assign cmd_addr   = value_reg & ADDR_MASK;

    assign set_addr_res = '{reg_select: RS_CMD,
                            bus_byte:   CURSOR_CMD_BIT | (BYTE_W'(cursor_reg) & ADDR_MASK),
                            last:       1'b0};
    assign data_res     = '{reg_select: RS_DATA, bus_byte: value_reg, last: 1'b1};
    assign cmd_res      = '{reg_select: RS_CMD,  bus_byte: value_reg, last: 1'b1};

    // Compare the shadow entry and decide the panel writes in the lookup cycle.
    always_comb
    begin
        cursor_next  = cursor_reg;
        panel_next   = panel_reg;
        wr_en        = 1'b0;
        q_req.load   = 1'b0;
        q_req.count  = 2'd0;
        q_req.first  = data_res;
        q_req.second = data_res;
        if (go)
        begin
            if (op_reg == OP_CHAR)
            begin
                cursor_next = cursor_inc;
                if (rd_data != value_reg)
                begin
                    wr_en      = 1'b1;
                    panel_next = cursor_inc;
                    q_req.load = 1'b1;
                    if (cursor_reg != panel_reg)
                    begin
                        q_req.count = 2'd2;
                        q_req.first = set_addr_res;
                    end
                    else
                    begin
                        q_req.count = 2'd1;
                    end
                end
            end
            else if ((value_reg & CURSOR_CMD_BIT) != '0)
            begin
                cursor_next = cmd_addr[ADDR_W-1:0];
            end
            else
            begin
                q_req.load  = 1'b1;
                q_req.count = 2'd1;
                q_req.first = cmd_res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cursor_reg <= '0;
            panel_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cursor_reg <= cursor_next;
            panel_reg  <= panel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= op;
            value_reg <= value;
        end
    end

    lsw_shadow_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (cursor_reg),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (cursor_reg),
        .wr_data (value_reg)
    );

    lsw_out_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (q_req),
        .pop   (pop),
        .empty (q_empty),
        .head  (q_head)
    );

    assign out_valid  = !q_empty;
    assign reg_select = q_head.reg_select;
    assign bus_byte   = q_head.bus_byte;
    assign last       = q_head.last;

endmodule

// File: tb/tb.sv
// Self-checking testbench for the LCD shadow write filter: directed, sweep and random traffic.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lsw_pkg::*;

    localparam int IDLE_LIMIT = 5000;

    logic              clk;
    logic              rst_n      = 1'b0;
    logic              in_valid   = 1'b0;
    logic              in_stall;
    logic              op         = OP_CHAR;
    logic [BYTE_W-1:0] value      = '0;
    logic              out_valid;
    logic              out_stall  = 1'b0;
    logic              reg_select;
    logic [BYTE_W-1:0] bus_byte;
    logic              last;

    // Shadow model of the block's state.
    logic [BYTE_W-1:0] shadow_mem [STORE_DEPTH];
    addr_t             logical_cur;
    addr_t             panel_cur;
    result_t           expected_writes [$];

    int      mismatch_count = 0;
    int      idle_cycles    = 0;
    int      hold_cnt       = 0;
    int      stall_pick;
    logic    stall_next     = 1'b0;
    bit      stall_enable   = 1'b1;
    bit      sender_gaps_on = 1'b1;
    result_t want;

    lcd_shadow_write_filter_unit DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .value      (value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .reg_select (reg_select),
        .bus_byte   (bus_byte),
        .last       (last)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Computes the panel writes that one accepted transaction causes and updates the model.
    task automatic model_panel_writes(input logic item_op, input logic [BYTE_W-1:0] item_value);
        addr_t             pos;
        logic [BYTE_W-1:0] pos_byte;
        result_t           wr;
        pos = logical_cur;
        pos_byte = pos;
        if (item_op == OP_CHAR)
        begin
            if (shadow_mem[pos] == item_value)
            begin
                logical_cur = pos + 1'b1;
            end
            else
            begin
                shadow_mem[pos] = item_value;
                if (pos != panel_cur)
                begin
                    wr.reg_select = RS_CMD;
                    wr.bus_byte   = CURSOR_CMD_BIT | (pos_byte & ADDR_MASK);
                    wr.last       = 1'b0;
                    expected_writes.push_back(wr);
                end
                wr.reg_select = RS_DATA;
                wr.bus_byte   = item_value;
                wr.last       = 1'b1;
                expected_writes.push_back(wr);
                logical_cur = pos + 1'b1;
                panel_cur   = logical_cur;
            end
        end
        else if ((item_value & CURSOR_CMD_BIT) != '0)
        begin
            // The store depth is a power of two, so truncation is the wrap.
            logical_cur = addr_t'(item_value & ADDR_MASK);
        end
        else
        begin
            wr.reg_select = RS_CMD;
            wr.bus_byte   = item_value;
            wr.last       = 1'b1;
            expected_writes.push_back(wr);
        end
    endtask

    task automatic send_item(input logic item_op, input logic [BYTE_W-1:0] item_value);
        in_valid <= 1'b1;
        op       <= item_op;
        value    <= item_value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        model_panel_writes(item_op, item_value);
    endtask

    // Mostly back-to-back, sometimes a short gap, rarely a long one.
    task automatic sender_gap();
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        n = 0;
        if (!sender_gaps_on || pick < 60)
            n = 0;
        else if (pick < 94)
            n = $urandom_range(1, 3);
        else
            n = $urandom_range(8, 30);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (expected_writes.size() != 0)
            @(posedge clk);
        // Transactions that cause no panel write may still be in flight.
        repeat (4) @(posedge clk);
    endtask

    // Text-like characters: often the one already shown, so that writes get suppressed.
    function automatic logic [BYTE_W-1:0] next_text_char();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            return shadow_mem[logical_cur];
        else if (pick < 80)
            return 8'h41 + 8'($urandom_range(0, 7));
        else
            return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_and_gap(input logic item_op, input logic [BYTE_W-1:0] item_value);
        send_item(item_op, item_value);
        sender_gap();
    endtask

    task automatic test_directed();
        send_and_gap(OP_CHAR, 8'h00);   // matches the cleared store
        send_and_gap(OP_CHAR, 8'hFF);   // cursors differ: set address, then data
        send_and_gap(OP_CHAR, 8'h41);   // cursors agree: data only
        send_and_gap(OP_CMD,  8'h01);
        send_and_gap(OP_CMD,  8'h7F);
        send_and_gap(OP_CMD,  8'h00);
        send_and_gap(OP_CMD,  8'h80);   // logical cursor back to zero
        send_and_gap(OP_CHAR, 8'h00);
        send_and_gap(OP_CHAR, 8'hFF);
        send_and_gap(OP_CHAR, 8'h42);
        send_and_gap(OP_CMD,  8'hFF);   // highest position a cursor command reaches
        send_and_gap(OP_CHAR, 8'h55);
        send_and_gap(OP_CHAR, 8'hAA);
        send_and_gap(OP_CMD,  8'h80);
        send_and_gap(OP_CMD,  8'h02);   // panel home does not move the tracked panel cursor
        send_and_gap(OP_CHAR, 8'h00);
        send_and_gap(OP_CHAR, 8'h7E);
        send_and_gap(OP_CHAR, 8'h80);
        send_and_gap(OP_CMD,  8'hC0);
        send_and_gap(OP_CHAR, 8'h01);
        wait_drain();
    endtask

    // Walks the cursor across the top of the store and around to zero, twice.
    task automatic test_cursor_wrap();
        repeat (2)
        begin
            send_and_gap(OP_CMD, CURSOR_CMD_BIT | ADDR_MASK);
            repeat (STORE_DEPTH / 2 + 8)
                send_and_gap(OP_CHAR, next_text_char());
        end
        wait_drain();
    endtask

    task automatic test_back_to_back(input int n_items);
        stall_enable   = 1'b0;
        sender_gaps_on = 1'b0;
        repeat (n_items)
        begin
            if ($urandom_range(0, 9) < 7)
                send_item(OP_CHAR, next_text_char());
            else
                send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        end
        wait_drain();
        stall_enable   = 1'b1;
        sender_gaps_on = 1'b1;
    endtask

    task automatic test_random_traffic(input int n_items);
        int sent;
        int pick;
        int run;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                // Reposition, then write a line of text.
                send_and_gap(OP_CMD, CURSOR_CMD_BIT | 8'($urandom_range(0, 127)));
                run = $urandom_range(1, 24);
                repeat (run)
                    send_and_gap(OP_CHAR, next_text_char());
                sent += run + 1;
            end
            else if (pick < 75)
            begin
                send_and_gap(OP_CHAR, 8'($urandom_range(0, 255)));
                sent++;
            end
            else if (pick < 90)
            begin
                send_and_gap(OP_CMD, 8'($urandom_range(0, 127)));
                sent++;
            end
            else
            begin
                send_and_gap(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
                sent++;
            end
            if ($urandom_range(0, 29) == 0)
                wait_drain();
        end
        wait_drain();
    endtask

    // Receiver stall pattern.
    always @(posedge clk)
    begin
        if (hold_cnt == 0)
        begin
            stall_pick = $urandom_range(0, 99);
            if (!stall_enable || stall_pick < 55)
            begin
                stall_next = 1'b0;
                hold_cnt   = $urandom_range(1, 16);
            end
            else if (stall_pick < 95)
            begin
                stall_next = 1'b1;
                hold_cnt   = $urandom_range(1, 3);
            end
            else
            begin
                stall_next = 1'b1;
                hold_cnt   = $urandom_range(8, 40);
            end
        end
        hold_cnt = hold_cnt - 1;
        out_stall <= stall_next;
    end

    // Compares every accepted panel write with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_writes.size() == 0)
            begin
                $error("unexpected panel write: reg_select %0d bus_byte 0x%02h last %0d",
                       reg_select, bus_byte, last);
                mismatch_count++;
            end
            else
            begin
                want = expected_writes.pop_front();
                if (reg_select !== want.reg_select)
                begin
                    $error("reg_select: expected %0d, got %0d", want.reg_select, reg_select);
                    mismatch_count++;
                end
                if (bus_byte !== want.bus_byte)
                begin
                    $error("bus_byte: expected 0x%02h, got 0x%02h", want.bus_byte, bus_byte);
                    mismatch_count++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, last);
                    mismatch_count++;
                end
            end
        end
    end

    // Ends the run if no transaction moves on either channel for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        for (int i = 0; i < STORE_DEPTH; i++)
            shadow_mem[i] = '0;
        logical_cur = '0;
        panel_cur   = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_back_to_back(200);
        test_cursor_wrap();
        test_random_traffic(1000);

        in_valid <= 1'b0;
        while (expected_writes.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (expected_writes.size() != 0)
        begin
            $error("%0d expected panel writes never arrived", expected_writes.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: lcd_shadow_write_filter_unit.f
sv/lsw_pkg.sv
sv/lsw_shadow_mem.sv
sv/lsw_out_queue.sv
sv/lcd_shadow_write_filter_unit.sv
tb/tb.sv
